[design/button_click_event_detector_defines.svh]
// ----------------------------------------------------------------------------
// button_click_event_detector_defines
// Assertion macros shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_EVENT_DETECTOR_DEFINES_SVH
`define BUTTON_CLICK_EVENT_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BCED_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BCED_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/bced_pkg.sv]
// ----------------------------------------------------------------------------
// bced_pkg
// Types, codes and widths of the button click event detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bced_pkg;

	localparam int CNT_W = 16;
	localparam int REG_W = 16;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_WINDOW     = 3'd0;
	localparam logic [IDX_W-1:0] REG_LONG_TICKS = 3'd1;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 3'd2;
	localparam logic [IDX_W-1:0] REG_TARGET     = 3'd3;
	localparam logic [IDX_W-1:0] REG_ACTIVE_LVL = 3'd4;

	localparam logic [REG_W-1:0] RST_WINDOW     = 16'd30;
	localparam logic [REG_W-1:0] RST_LONG_TICKS = 16'd100;
	localparam logic [REG_W-1:0] RST_DEBOUNCE   = 16'd3;
	localparam logic [REG_W-1:0] RST_TARGET     = 16'd2;

	typedef enum logic [1:0] {
		PRESS_NONE         = 2'd0,
		PRESS_LONG_CLICK   = 2'd1,
		PRESS_LONG_RELEASE = 2'd2,
		PRESS_LONG_HOLD    = 2'd3
	} press_ev_t;

	typedef enum logic [1:0] {
		CLICK_NONE  = 2'd0,
		CLICK_SHORT = 2'd1,
		CLICK_MULTI = 2'd2
	} click_ev_t;

	typedef struct packed {
		logic [CNT_W-1:0] window;
		logic [CNT_W-1:0] long_ticks;
		logic [CNT_W-1:0] debounce;
		logic [CNT_W-1:0] target;
		logic             active_level;
	} cfg_t;

	typedef struct packed {
		press_ev_t press_event;
		click_ev_t click_event;
	} result_t;

endpackage

`default_nettype wire

[design/bced_cfg.sv]
// ----------------------------------------------------------------------------
// bced_cfg
// Configuration register file, write only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bced_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bced_pkg::IDX_W-1:0]   cfg_index,
	input  wire logic [bced_pkg::REG_W-1:0]   cfg_wdata,
	output bced_pkg::cfg_t                    cfg
);

	bced_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window       <= bced_pkg::RST_WINDOW;
			cfg_q.long_ticks   <= bced_pkg::RST_LONG_TICKS;
			cfg_q.debounce     <= bced_pkg::RST_DEBOUNCE;
			cfg_q.target       <= bced_pkg::RST_TARGET;
			cfg_q.active_level <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bced_pkg::REG_WINDOW:     cfg_q.window       <= cfg_wdata;
				bced_pkg::REG_LONG_TICKS: cfg_q.long_ticks   <= cfg_wdata;
				bced_pkg::REG_DEBOUNCE:   cfg_q.debounce     <= cfg_wdata;
				bced_pkg::REG_TARGET:     cfg_q.target       <= cfg_wdata;
				bced_pkg::REG_ACTIVE_LVL: cfg_q.active_level <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/bced_core.sv]
// ----------------------------------------------------------------------------
// bced_core
// Press/click state and the per-tick next-state and event logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bced_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic       pin_level,
	input  wire bced_pkg::cfg_t cfg,
	output bced_pkg::result_t result
);

	localparam int W = bced_pkg::CNT_W;

	logic         phase_q;
	logic [W-1:0] deb_q;
	logic [W-1:0] tick_q;
	logic [W-1:0] rel_q;
	logic [W-1:0] frt_q;
	logic         lf_q;

	logic         phase_d;
	logic [W-1:0] deb_d;
	logic [W-1:0] tick_d;
	logic [W-1:0] rel_d;
	logic [W-1:0] frt_d;
	logic         lf_d;

	logic         active;
	logic [W-1:0] tick_inc;
	logic [W-1:0] deb_inc;
	logic [W-1:0] span;
	logic         wrap;
	bced_pkg::press_ev_t pe;
	bced_pkg::click_ev_t ce;

	always_comb begin
		active   = (pin_level == cfg.active_level);
		tick_inc = (phase_q || (rel_q != '0)) ? tick_q + W'(1) : tick_q;
		deb_inc  = deb_q + W'(1);
		phase_d  = phase_q;
		deb_d    = deb_q;
		tick_d   = tick_inc;
		rel_d    = rel_q;
		frt_d    = frt_q;
		lf_d     = lf_q;
		pe       = bced_pkg::PRESS_NONE;
		ce       = bced_pkg::CLICK_NONE;

		if (!phase_q) begin
			if (active) begin
				if (deb_inc >= cfg.debounce) begin
					deb_d   = '0;
					phase_d = 1'b1;
				end else begin
					deb_d = deb_inc;
				end
			end else begin
				deb_d = '0;
			end
		end else begin
			priority if (active && !lf_q && (tick_inc >= cfg.long_ticks)) begin
				lf_d = 1'b1;
				pe   = bced_pkg::PRESS_LONG_CLICK;
			end else if (!active) begin
				phase_d = 1'b0;
				if (lf_q) begin
					tick_d = '0;
					rel_d  = '0;
					lf_d   = 1'b0;
					pe     = bced_pkg::PRESS_LONG_RELEASE;
				end else begin
					if (rel_q == '0)
						frt_d = tick_inc;
					rel_d = rel_q + W'(1);
				end
			end else if (lf_q) begin
				pe = bced_pkg::PRESS_LONG_HOLD;
			end else begin
				pe = bced_pkg::PRESS_NONE;
			end
		end

		// wrapped difference adds the mask, not the modulus: one less
		wrap = (tick_d < frt_d);
		span = tick_d - frt_d - W'(wrap);

		priority if ((span > cfg.window) && (rel_d != '0)) begin
			ce = bced_pkg::CLICK_SHORT;
		end else if ((span < cfg.window) && (rel_d == cfg.target)) begin
			ce = bced_pkg::CLICK_MULTI;
		end else begin
			ce = bced_pkg::CLICK_NONE;
		end
		if (ce != bced_pkg::CLICK_NONE) begin
			rel_d  = '0;
			tick_d = '0;
			frt_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			deb_q   <= '0;
			tick_q  <= '0;
			rel_q   <= '0;
			frt_q   <= '0;
			lf_q    <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			deb_q   <= deb_d;
			tick_q  <= tick_d;
			rel_q   <= rel_d;
			frt_q   <= frt_d;
			lf_q    <= lf_d;
		end
	end

	assign result.press_event = pe;
	assign result.click_event = ce;

endmodule

`default_nettype wire

[design/button_click_event_detector.sv]
// ----------------------------------------------------------------------------
// button_click_event_detector
// Debounced button with long-press and short/multi-click detection.
// ----------------------------------------------------------------------------
// Each transfer on the slave side is one tick with one pin sample; each tick
// yields exactly one result transfer on the master side. The sample sits in an
// input register, the state update and event decode run combinationally between
// that register and the result register, so one tick is taken per clock while
// the master side keeps up. Registers take effect at once, so write them only
// while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none

module button_click_event_detector (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [bced_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [bced_pkg::REG_W-1:0]  cfg_wdata,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [7:0]                  s_axis_tdata,  // [0] pin_level
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [7:0]                       m_axis_tdata   // [1:0] press_event, [3:2] click_event
);

	bced_pkg::cfg_t    cfg;
	bced_pkg::result_t result;

	logic              valid_s1;
	logic              pin_s1;
	logic              out_valid_q;
	bced_pkg::result_t out_q;
	logic              advance;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	bced_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bced_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pin_level (pin_s1),
		.cfg       (cfg),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			pin_s1 <= s_axis_tdata[0];
		if (advance)
			out_q <= result;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_q.click_event, out_q.press_event};

endmodule

`default_nettype wire

[design/bced_checker.sv]
// ----------------------------------------------------------------------------
// bced_checker
// Port-level checks for the button click event detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "button_click_event_detector_defines.svh"

module bced_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tready,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata
);

	`BCED_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

	`BCED_ASSERT_NOW(a_no_stall_in, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input stalled without output backpressure")

	`BCED_ASSERT_NOW(a_click_code, m_axis_tvalid, m_axis_tdata[3:2] != 2'b11, "undefined click code")

	`BCED_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:4] == 4'b0000, "pad bits not zero")

endmodule

bind button_click_event_detector bced_checker u_bced_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the button click event detector. Pin samples go in
// on the slave stream, one tick per transfer. Each accepted tick runs through
// a local model of the debounce, long-press and click-window logic, and the
// result transfer on the master stream is compared with the oldest pending
// event. A short directed table opens the run. Randomized press and release
// gestures follow under several register settings and handshake patterns,
// with a short run of alternating samples under no debounce and a zero target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import bced_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int MAX_REPORTS = 40;
	localparam int SOAK_TICKS = 30;
	localparam logic ROW_TICK = 1'b0;
	localparam logic ROW_CFG = 1'b1;
	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam result_t QUIET = '{PRESS_NONE, CLICK_NONE};

	typedef struct packed {
		logic             is_cfg;
		logic [IDX_W-1:0] idx;
		logic [REG_W-1:0] val;   // register value, or pin in bit 0
		logic             typed;
		result_t          want;
	} dir_row_t;

	localparam dir_row_t DIRECTED [25] = '{
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b1, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b1, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b1, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b1, QUIET},
		'{ROW_CFG, REG_LONG_TICKS, 16'd2, 1'b0, QUIET},
		'{ROW_CFG, REG_WINDOW, 16'd3, 1'b0, QUIET},
		'{ROW_CFG, REG_DEBOUNCE, 16'd0, 1'b0, QUIET},
		'{ROW_CFG, REG_ACTIVE_LVL, 16'd1, 1'b0, QUIET},
		'{ROW_CFG, REG_UNUSED, 16'hFFFF, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd1, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET},
		'{ROW_TICK, REG_WINDOW, 16'd0, 1'b0, QUIET}
	};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [REG_W-1:0] cfg_wdata = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [7:0]       s_axis_tdata = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [7:0]       m_axis_tdata;

	// shadow registers
	logic [CNT_W-1:0] cfg_window = RST_WINDOW;
	logic [CNT_W-1:0] cfg_long = RST_LONG_TICKS;
	logic [CNT_W-1:0] cfg_debounce = RST_DEBOUNCE;
	logic [CNT_W-1:0] cfg_target = RST_TARGET;
	logic             cfg_active = 1'b0;

	// button state
	logic             btn_pressed = 1'b0;
	logic [CNT_W-1:0] btn_debounce = '0;
	logic [CNT_W-1:0] btn_ticks = '0;
	logic [CNT_W-1:0] btn_releases = '0;
	logic [CNT_W-1:0] btn_first_rel = '0;
	logic             btn_long = 1'b0;

	result_t pending_events [$];
	result_t due_event;
	int      fail_count = 0;
	int      sent_count = 0;
	int      idle_pct = 0;
	int      stall_pct = 0;
	int      hold_left = 0;
	int      cycle_count = 0;

	button_click_event_detector u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t advance_tick(input logic pin);
		result_t          r;
		logic             hot;
		logic [CNT_W-1:0] span;
		r = QUIET;
		hot = (pin == cfg_active);
		if (btn_pressed || btn_releases != 0)
			btn_ticks = btn_ticks + 16'd1;
		if (!btn_pressed) begin
			if (hot) begin
				btn_debounce = btn_debounce + 16'd1;
				if (btn_debounce >= cfg_debounce) begin
					btn_debounce = '0;
					btn_pressed = 1'b1;
				end
			end else begin
				btn_debounce = '0;
			end
		end else if (hot && !btn_long && btn_ticks >= cfg_long) begin
			btn_long = 1'b1;
			r.press_event = PRESS_LONG_CLICK;
		end else if (!hot) begin
			btn_pressed = 1'b0;
			if (btn_long) begin
				btn_ticks = '0;
				btn_releases = '0;
				btn_long = 1'b0;
				r.press_event = PRESS_LONG_RELEASE;
			end else begin
				if (btn_releases == 0)
					btn_first_rel = btn_ticks;
				btn_releases = btn_releases + 16'd1;
			end
		end else if (btn_long) begin
			r.press_event = PRESS_LONG_HOLD;
		end
		// wrapped difference adds the mask, one short of the modulus
		if (btn_ticks < btn_first_rel)
			span = btn_ticks + 16'hFFFF - btn_first_rel;
		else
			span = btn_ticks - btn_first_rel;
		if (span > cfg_window && btn_releases != 0) begin
			btn_releases = '0;
			btn_ticks = '0;
			btn_first_rel = '0;
			r.click_event = CLICK_SHORT;
		end else if (span < cfg_window && btn_releases == cfg_target) begin
			btn_releases = '0;
			btn_ticks = '0;
			btn_first_rel = '0;
			r.click_event = CLICK_MULTI;
		end
		return r;
	endfunction

	function automatic int clip40(input int v);
		return (v > 40) ? 40 : v;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s: got %0d, want %0d", $time, what, got, want);
	endtask

	// one tick transfer; called and returns at a falling edge
	task automatic send_tick(input logic pin, input logic typed, input result_t want);
		result_t r;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, pin};
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		r = advance_tick(pin);
		pending_events.push_back(typed ? want : r);
		sent_count++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		unique case (idx)
			REG_WINDOW:     cfg_window = val;
			REG_LONG_TICKS: cfg_long = val;
			REG_DEBOUNCE:   cfg_debounce = val;
			REG_TARGET:     cfg_target = val;
			REG_ACTIVE_LVL: cfg_active = val[0];
			default: ;
		endcase
	endtask

	task automatic set_mode(input logic [REG_W-1:0] window, input logic [REG_W-1:0] long_t,
			input logic [REG_W-1:0] deb, input logic [REG_W-1:0] target, input logic act);
		settle();
		write_reg(REG_WINDOW, window);
		write_reg(REG_LONG_TICKS, long_t);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_TARGET, target);
		write_reg(REG_ACTIVE_LVL, {15'b0, act});
	endtask

	// press of some length followed by a release, or a burst of noise
	task automatic send_gesture();
		int   held;
		int   gap_len;
		int   k;
		logic up;
		up = cfg_active;
		case ($urandom_range(0, 3))
			0: held = $urandom_range(1, clip40(int'(cfg_debounce) + 2));
			1: held = clip40(int'(cfg_debounce) + int'(cfg_long)) + $urandom_range(0, 3);
			2: held = $urandom_range(1, 4);
			default: begin
				held = 0;
				repeat ($urandom_range(1, 6))
					send_tick(1'($urandom_range(0, 1)), 1'b0, QUIET);
			end
		endcase
		if (held != 0) begin
			gap_len = $urandom_range(1, clip40(int'(cfg_window) + 3));
			for (k = 0; k < held; k++)
				send_tick(up, 1'b0, QUIET);
			for (k = 0; k < gap_len; k++)
				send_tick(~up, 1'b0, QUIET);
		end
	endtask

	task automatic run_random(input int n, input int idle, input int stall);
		int start;
		start = sent_count;
		idle_pct = idle;
		stall_pct = stall;
		while (sent_count - start < n)
			send_gesture();
	endtask

	// result side
	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			if (pending_events.size() == 0) begin
				flag_mismatch("result transfer with nothing pending", m_axis_tdata, 0);
			end else begin
				due_event = pending_events.pop_front();
				if (m_axis_tdata[1:0] !== due_event.press_event)
					flag_mismatch("press_event", m_axis_tdata[1:0], due_event.press_event);
				if (m_axis_tdata[3:2] !== due_event.click_event)
					flag_mismatch("click_event", m_axis_tdata[3:2], due_event.click_event);
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("button_click_event_detector: mismatch");
		$finish;
	end

	initial begin
		int k;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < 25; k++) begin
			if (DIRECTED[k].is_cfg == ROW_CFG) begin
				settle();
				write_reg(DIRECTED[k].idx, DIRECTED[k].val);
			end else begin
				send_tick(DIRECTED[k].val[0], DIRECTED[k].typed, DIRECTED[k].want);
			end
		end

		set_mode(16'd8, 16'd6, 16'd1, 16'd2, 1'b0);
		run_random(50, 0, 0);
		settle();
		run_random(50, 0, 0);

		set_mode(16'd0, 16'd0, 16'd0, 16'd1, 1'b1);
		run_random(70, 63, 0);

		set_mode(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		run_random(30, 0, 63);
		set_mode(16'd12, 16'hFFFF, 16'd1, 16'hFFFF, 1'b1);
		run_random(40, 0, 63);

		set_mode(16'd5, 16'd10, 16'd2, 16'd3, 1'b0);
		run_random(80, 16, 16);

		// zero target, with a long hold-off on the result side
		set_mode(16'd4, 16'd8, 16'd1, 16'd0, 1'b1);
		hold_left = 60;
		run_random(70, 0, 0);

		// alternating samples with no debounce and a zero target
		set_mode(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b1);
		idle_pct = 0;
		stall_pct = 0;
		for (k = 0; k < SOAK_TICKS; k++)
			send_tick(~k[0], 1'b0, QUIET);

		set_mode(16'd3, 16'd4, 16'd0, 16'd2, 1'b0);
		run_random(30, 16, 16);

		stall_pct = 0;
		settle();
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("button_click_event_detector: match");
		else
			$display("button_click_event_detector: mismatch");
		$finish;
	end

endmodule
